// ===== rtl/gopc_pkg.sv =====
`default_nettype none
package gopc_pkg;

  localparam int COORD_W    = 10;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int PPU_W      = 10;
  localparam int QUOT_MAX_W = 12;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = APB_AW - 2;

  typedef logic [RGB_W-1:0]     rgb_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_column;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [PPU_W-1:0] ppu;
    rgb_t             fine;
    rgb_t             mid;
    rgb_t             coarse;
    rgb_t             vaxis;
    rgb_t             haxis;
  } cfg_t;

  typedef struct packed {
    logic outside;
    logic hband;
    logic vband;
    logic row_zero;
    logic col_zero;
    logic near_origin;
  } flags_t;

  typedef enum logic [2:0] {
    CLS_WHITE,
    CLS_BLACK,
    CLS_FINE,
    CLS_MEDIUM,
    CLS_COARSE,
    CLS_VAXIS,
    CLS_HAXIS
  } class_t;

  localparam reg_idx_t REG_PPU    = 3'd0;
  localparam reg_idx_t REG_FINE   = 3'd1;
  localparam reg_idx_t REG_MEDIUM = 3'd2;
  localparam reg_idx_t REG_COARSE = 3'd3;
  localparam reg_idx_t REG_VAXIS  = 3'd4;
  localparam reg_idx_t REG_HAXIS  = 3'd5;

  localparam logic [PPU_W-1:0] PPU_RESET    = 10'd51;
  localparam rgb_t             FINE_RESET   = 24'hCCCCCC;
  localparam rgb_t             MEDIUM_RESET = 24'h666666;
  localparam rgb_t             COARSE_RESET = 24'h000000;
  localparam rgb_t             VAXIS_RESET  = 24'hFF0000;
  localparam rgb_t             HAXIS_RESET  = 24'h00FF00;
  localparam rgb_t             WHITE_RGB    = 24'hFFFFFF;
  localparam rgb_t             BLACK_RGB    = 24'h000000;

  // 16 = 1 mod 5, so nibble sums keep the residue
  function automatic logic is_mult5(input logic [QUOT_MAX_W-1:0] q);
    logic [5:0] s;
    logic [4:0] t;
    s = 6'(q[3:0]) + 6'(q[7:4]) + 6'(q[11:8]);
    t = 5'(s[5:4]) + 5'(s[3:0]);
    return (t == 5'd0) || (t == 5'd5) || (t == 5'd10) || (t == 5'd15);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/grid_overlay_pixel_classifier.sv =====
// each pix item passes the front register, the divider steps and the resolve registers to rgb
// throughput: one item per clock unless rgb_ready stalls, set by the one-bit-per-stage divider chain
// a low rgb_ready while rgb_valid is high holds every stage in place; nothing is dropped or repeated
// reset clears all stage valid bits and loads the register reset values
`default_nettype none
module grid_overlay_pixel_classifier
  import gopc_pkg::*;
#(
  parameter int IMAGE_SIZE  = 1024,
  parameter int ORIGIN_HALF = 5,
  parameter int AXIS_WIDTH  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire pixel_t            pix,
  output logic                   rgb_valid,
  input  wire logic              rgb_ready,
  output color_t                 rgb,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int EW = ($clog2(IMAGE_SIZE + 1) > COORD_W) ? $clog2(IMAGE_SIZE + 1) : COORD_W;
  localparam int OW = $clog2(IMAGE_SIZE / 2 + 1);

  cfg_t             cfg;
  logic             en;
  logic             div_valid [OW+1];
  flags_t           div_flags [OW+1];
  logic [OW-1:0]    row_a     [OW+1];
  logic [OW-1:0]    col_a     [OW+1];
  logic [PPU_W-1:0] row_rem   [OW+1];
  logic [PPU_W-1:0] col_rem   [OW+1];

  assign en        = !rgb_valid || rgb_ready;
  assign pix_ready = en;

  gopc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gopc_front #(
    .IMAGE_SIZE  (IMAGE_SIZE),
    .ORIGIN_HALF (ORIGIN_HALF),
    .AXIS_WIDTH  (AXIS_WIDTH),
    .EW          (EW),
    .OW          (OW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (pix_valid),
    .pix      (pix),
    .valid    (div_valid[0]),
    .flags    (div_flags[0]),
    .row_off  (row_a[0]),
    .col_off  (col_a[0])
  );

  assign row_rem[0] = '0;
  assign col_rem[0] = '0;

  for (genvar i = 0; i < OW; i++) begin : g_div
    gopc_div_step #(
      .OW (OW)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .valid_in   (div_valid[i]),
      .flags_in   (div_flags[i]),
      .ppu        (cfg.ppu),
      .row_a_in   (row_a[i]),
      .row_rem_in (row_rem[i]),
      .col_a_in   (col_a[i]),
      .col_rem_in (col_rem[i]),
      .valid      (div_valid[i+1]),
      .flags      (div_flags[i+1]),
      .row_a      (row_a[i+1]),
      .row_rem    (row_rem[i+1]),
      .col_a      (col_a[i+1]),
      .col_rem    (col_rem[i+1])
    );
  end

  gopc_resolve #(
    .OW (OW)
  ) u_resolve (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (div_valid[OW]),
    .flags    (div_flags[OW]),
    .row_q    (row_a[OW]),
    .row_rem  (row_rem[OW]),
    .col_q    (col_a[OW]),
    .col_rem  (col_rem[OW]),
    .cfg      (cfg),
    .valid    (rgb_valid),
    .color    (rgb)
  );

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_valid[OW] |-> (row_rem[OW] < cfg.ppu) && (col_rem[OW] < cfg.ppu))
    else $error("divider remainder not below spacing");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |=> $stable(div_valid[OW]) && $stable(row_a[OW]) && $stable(col_a[OW]))
    else $error("divider chain moved during stall");

  a_div_advance: assert property (@(posedge clk) disable iff (rst)
    pix_ready |=> div_valid[1] == $past(div_valid[0]))
    else $error("item lost or repeated entering divider");

endmodule
`default_nettype wire

// ===== rtl/gopc_regs.sv =====
`default_nettype none
module gopc_regs
  import gopc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [PPU_W-1:0] ppu_raw;
  rgb_t             fine;
  rgb_t             mid;
  rgb_t             coarse;
  rgb_t             vaxis;
  rgb_t             haxis;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppu_raw <= PPU_RESET;
      fine    <= FINE_RESET;
      mid     <= MEDIUM_RESET;
      coarse  <= COARSE_RESET;
      vaxis   <= VAXIS_RESET;
      haxis   <= HAXIS_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PPU:    ppu_raw <= pwdata[PPU_W-1:0];
        REG_FINE:   fine    <= pwdata[RGB_W-1:0];
        REG_MEDIUM: mid     <= pwdata[RGB_W-1:0];
        REG_COARSE: coarse  <= pwdata[RGB_W-1:0];
        REG_VAXIS:  vaxis   <= pwdata[RGB_W-1:0];
        REG_HAXIS:  haxis   <= pwdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PPU:    prdata = APB_DW'(ppu_raw);
      REG_FINE:   prdata = APB_DW'(fine);
      REG_MEDIUM: prdata = APB_DW'(mid);
      REG_COARSE: prdata = APB_DW'(coarse);
      REG_VAXIS:  prdata = APB_DW'(vaxis);
      REG_HAXIS:  prdata = APB_DW'(haxis);
      default:    prdata = '0;
    endcase
  end

  // zero spacing acts as one
  assign cfg.ppu    = (ppu_raw == '0) ? PPU_W'(1) : ppu_raw;
  assign cfg.fine   = fine;
  assign cfg.mid    = mid;
  assign cfg.coarse = coarse;
  assign cfg.vaxis  = vaxis;
  assign cfg.haxis  = haxis;

endmodule
`default_nettype wire

// ===== rtl/gopc_front.sv =====
`default_nettype none
module gopc_front
  import gopc_pkg::*;
#(
  parameter int IMAGE_SIZE  = 1024,
  parameter int ORIGIN_HALF = 5,
  parameter int AXIS_WIDTH  = 5,
  parameter int EW          = 11,
  parameter int OW          = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire pixel_t        pix,
  output logic               valid,
  output flags_t             flags,
  output logic      [OW-1:0] row_off,
  output logic      [OW-1:0] col_off
);

  localparam logic [EW-1:0] SIZE     = EW'(IMAGE_SIZE);
  localparam logic [EW-1:0] CENTER   = EW'(IMAGE_SIZE / 2);
  localparam logic [EW-1:0] BAND_END = EW'(IMAGE_SIZE / 2 + AXIS_WIDTH);
  localparam logic [EW-1:0] HALF     = EW'(ORIGIN_HALF);

  logic [EW-1:0] row_x;
  logic [EW-1:0] col_x;
  logic [EW-1:0] r_off;
  logic [EW-1:0] c_off;
  flags_t        flags_next;

  always_comb begin
    row_x = EW'(pix.pixel_row);
    col_x = EW'(pix.pixel_column);
    r_off = (row_x >= CENTER) ? (row_x - CENTER) : (CENTER - row_x);
    c_off = (col_x >= CENTER) ? (col_x - CENTER) : (CENTER - col_x);
    flags_next.outside     = (row_x >= SIZE) || (col_x >= SIZE);
    flags_next.hband       = (row_x >= CENTER) && (row_x < BAND_END);
    flags_next.vband       = (col_x >= CENTER) && (col_x < BAND_END);
    flags_next.row_zero    = (r_off == '0);
    flags_next.col_zero    = (c_off == '0);
    flags_next.near_origin = (r_off <= HALF) && (c_off <= HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags   <= flags_next;
      row_off <= r_off[OW-1:0];
      col_off <= c_off[OW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gopc_div_step.sv =====
`default_nettype none
module gopc_div_step
  import gopc_pkg::*;
#(
  parameter int OW = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             valid_in,
  input  wire flags_t           flags_in,
  input  wire logic [PPU_W-1:0] ppu,
  input  wire logic [OW-1:0]    row_a_in,
  input  wire logic [PPU_W-1:0] row_rem_in,
  input  wire logic [OW-1:0]    col_a_in,
  input  wire logic [PPU_W-1:0] col_rem_in,
  output logic                  valid,
  output flags_t                flags,
  output logic      [OW-1:0]    row_a,
  output logic      [PPU_W-1:0] row_rem,
  output logic      [OW-1:0]    col_a,
  output logic      [PPU_W-1:0] col_rem
);

  logic [PPU_W:0]   row_t;
  logic [PPU_W:0]   col_t;
  logic [PPU_W:0]   div_x;
  logic             row_ge;
  logic             col_ge;
  logic [PPU_W-1:0] row_rem_next;
  logic [PPU_W-1:0] col_rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    div_x        = {1'b0, ppu};
    row_t        = {row_rem_in, row_a_in[OW-1]};
    col_t        = {col_rem_in, col_a_in[OW-1]};
    row_ge       = row_t >= div_x;
    col_ge       = col_t >= div_x;
    row_rem_next = row_ge ? PPU_W'(row_t - div_x) : row_t[PPU_W-1:0];
    col_rem_next = col_ge ? PPU_W'(col_t - div_x) : col_t[PPU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags   <= flags_in;
      row_a   <= {row_a_in[OW-2:0], row_ge};
      col_a   <= {col_a_in[OW-2:0], col_ge};
      row_rem <= row_rem_next;
      col_rem <= col_rem_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gopc_resolve.sv =====
`default_nettype none
module gopc_resolve
  import gopc_pkg::*;
#(
  parameter int OW = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             valid_in,
  input  wire flags_t           flags,
  input  wire logic [OW-1:0]    row_q,
  input  wire logic [PPU_W-1:0] row_rem,
  input  wire logic [OW-1:0]    col_q,
  input  wire logic [PPU_W-1:0] col_rem,
  input  wire cfg_t             cfg,
  output logic                  valid,
  output color_t                color
);

  logic   cls_valid;
  class_t cls;
  class_t cls_next;
  rgb_t   rgb_next;
  logic   row_mult;
  logic   col_mult;
  logic   row_m5;
  logic   col_m5;
  logic   row_m10;
  logic   col_m10;

  always_comb begin
    row_mult = !flags.row_zero && (row_rem == '0);
    col_mult = !flags.col_zero && (col_rem == '0);
    row_m5   = row_mult && is_mult5(QUOT_MAX_W'(row_q));
    col_m5   = col_mult && is_mult5(QUOT_MAX_W'(col_q));
    row_m10  = row_m5 && !row_q[0];
    col_m10  = col_m5 && !col_q[0];
    if (flags.outside) begin
      cls_next = CLS_WHITE;
    end else if (flags.hband) begin
      cls_next = CLS_HAXIS;
    end else if (flags.vband) begin
      cls_next = CLS_VAXIS;
    end else if (row_m10 || col_m10) begin
      cls_next = CLS_COARSE;
    end else if (row_m5 || col_m5) begin
      cls_next = CLS_MEDIUM;
    end else if (row_mult || col_mult) begin
      cls_next = CLS_FINE;
    end else if (flags.near_origin) begin
      cls_next = CLS_BLACK;
    end else begin
      cls_next = CLS_WHITE;
    end
  end

  always_comb begin
    unique case (cls)
      CLS_WHITE:  rgb_next = WHITE_RGB;
      CLS_BLACK:  rgb_next = BLACK_RGB;
      CLS_FINE:   rgb_next = cfg.fine;
      CLS_MEDIUM: rgb_next = cfg.mid;
      CLS_COARSE: rgb_next = cfg.coarse;
      CLS_VAXIS:  rgb_next = cfg.vaxis;
      CLS_HAXIS:  rgb_next = cfg.haxis;
      default:    rgb_next = WHITE_RGB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
      valid     <= 1'b0;
    end else if (en) begin
      cls_valid <= valid_in;
      valid     <= cls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls   <= cls_next;
      color <= color_t'(rgb_next);
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
  import gopc_pkg::*;

  localparam int IMG         = 1024;
  localparam int CENTER      = IMG / 2;
  localparam int ORIGIN_HALF = 5;
  localparam int AXIS_W      = 5;
  localparam int NUM_SETTINGS    = 8;
  localparam int PIXELS_PER_SET  = 235;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               known;
    rgb_t               color;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  pixel_t              pix = '0;
  logic                rgb_valid;
  logic                rgb_ready = 1'b0;
  color_t              rgb;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  cfg_t shadow = {PPU_RESET, FINE_RESET, MEDIUM_RESET, COARSE_RESET, VAXIS_RESET, HAXIS_RESET};
  color_t pending_colors [$];
  int error_count = 0;
  int cycle_count = 0;
  int pixels_sent = 0;
  int colors_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_requests = 0;
  int holdoffs_served = 0;
  int hold_count = 0;

  probe_t probes [0:19] = '{
    '{10'd0,    10'd0,    1'b1, WHITE_RGB},
    '{10'd1023, 10'd1023, 1'b1, WHITE_RGB},
    '{10'd512,  10'd0,    1'b1, HAXIS_RESET},
    '{10'd516,  10'd1023, 1'b1, HAXIS_RESET},
    '{10'd517,  10'd512,  1'b1, VAXIS_RESET},
    '{10'd0,    10'd516,  1'b1, VAXIS_RESET},
    '{10'd512,  10'd512,  1'b1, HAXIS_RESET},
    '{10'd511,  10'd511,  1'b1, BLACK_RGB},
    '{10'd507,  10'd507,  1'b1, BLACK_RGB},
    '{10'd506,  10'd511,  1'b1, WHITE_RGB},
    '{10'd511,  10'd517,  1'b1, BLACK_RGB},
    '{10'd511,  10'd518,  1'b1, WHITE_RGB},
    '{10'd563,  10'd100,  1'b1, FINE_RESET},
    '{10'd767,  10'd0,    1'b1, MEDIUM_RESET},
    '{10'd2,    10'd0,    1'b1, COARSE_RESET},
    '{10'd1022, 10'd1023, 1'b1, COARSE_RESET},
    '{10'd461,  10'd1000, 1'b1, FINE_RESET},
    '{10'd612,  10'd300,  1'b0, '0},
    '{10'd100,  10'd1023, 1'b0, '0},
    '{10'd1023, 10'd0,    1'b0, '0}
  };

  logic [PPU_W-1:0] unit_settings [0:NUM_SETTINGS-1] = '{
    10'd1, 10'd0, 10'd512, 10'd1023, 10'd2, 10'd7, 10'd51, 10'd3
  };

  grid_overlay_pixel_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit on_line(input int offset, input int spacing);
    return offset != 0 && (offset % spacing) == 0;
  endfunction

  function automatic color_t pixel_color(input pixel_t p);
    int row, col, roff, coff, unit;
    rgb_t c;
    row  = p.pixel_row;
    col  = p.pixel_column;
    unit = (shadow.ppu == 0) ? 1 : int'(shadow.ppu);
    roff = (row >= CENTER) ? row - CENTER : CENTER - row;
    coff = (col >= CENTER) ? col - CENTER : CENTER - col;
    if (row >= IMG || col >= IMG) c = WHITE_RGB;
    else if (row >= CENTER && row < CENTER + AXIS_W) c = shadow.haxis;
    else if (col >= CENTER && col < CENTER + AXIS_W) c = shadow.vaxis;
    else if (on_line(roff, 10 * unit) || on_line(coff, 10 * unit)) c = shadow.coarse;
    else if (on_line(roff, 5 * unit) || on_line(coff, 5 * unit)) c = shadow.mid;
    else if (on_line(roff, unit) || on_line(coff, unit)) c = shadow.fine;
    else if (roff <= ORIGIN_HALF && coff <= ORIGIN_HALF) c = BLACK_RGB;
    else c = WHITE_RGB;
    return color_t'(c);
  endfunction

  function automatic pixel_t random_pixel();
    int unit, kind, row, col, max_k, k, pos;
    pixel_t p;
    unit = (shadow.ppu == 0) ? 1 : int'(shadow.ppu);
    kind = $urandom_range(99);
    row  = $urandom_range(IMG - 1);
    col  = $urandom_range(IMG - 1);
    max_k = CENTER / unit;
    if (kind < 45 && max_k > 0) begin
      k = $urandom_range(max_k, 1);
      if ($urandom_range(1) && max_k >= 10) k = 10 * $urandom_range(max_k / 10, 1);
      else if ($urandom_range(1) && max_k >= 5) k = 5 * $urandom_range(max_k / 5, 1);
      pos = $urandom_range(1) ? CENTER + k * unit : CENTER - k * unit;
      if (pos >= IMG) pos = CENTER - k * unit;
      if ($urandom_range(1)) row = pos;
      else col = pos;
    end else if (kind < 65) begin
      row = CENTER - 8 + $urandom_range(16);
      col = CENTER - 8 + $urandom_range(16);
    end else if (kind < 80) begin
      if ($urandom_range(1)) row = CENTER - 1 + $urandom_range(AXIS_W + 1);
      else col = CENTER - 1 + $urandom_range(AXIS_W + 1);
    end
    p.pixel_row    = row[COORD_W-1:0];
    p.pixel_column = col[COORD_W-1:0];
    return p;
  endfunction

  // result side: check, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (rgb_valid && rgb_ready) begin
        if (pending_colors.size() == 0) begin
          $error("unexpected item on rgb: %0h", rgb);
          error_count++;
        end else begin
          color_t want;
          want = pending_colors.pop_front();
          colors_checked++;
          if (rgb.red !== want.red) begin
            $error("red: expected %0h, got %0h", want.red, rgb.red);
            error_count++;
          end
          if (rgb.green !== want.green) begin
            $error("green: expected %0h, got %0h", want.green, rgb.green);
            error_count++;
          end
          if (rgb.blue !== want.blue) begin
            $error("blue: expected %0h, got %0h", want.blue, rgb.blue);
            error_count++;
          end
        end
      end
      if (holdoffs_served < holdoff_requests) begin
        rgb_ready <= 1'b0;
        hold_count++;
        if (hold_count == HOLD_CYCLES) begin
          hold_count = 0;
          holdoffs_served++;
        end
      end else begin
        rgb_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_pixel(input pixel_t p, input color_t want);
    if (holdoffs_served == holdoff_requests && $urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= p;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    pending_colors.push_back(want);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // leaves psel high so back-to-back writes need no idle bus cycle
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = '0;
    case (idx)
      REG_PPU: begin
        shadow.ppu = value[PPU_W-1:0];
        want[PPU_W-1:0] = shadow.ppu;
      end
      REG_FINE: begin
        shadow.fine = value[RGB_W-1:0];
        want[RGB_W-1:0] = shadow.fine;
      end
      REG_MEDIUM: begin
        shadow.mid = value[RGB_W-1:0];
        want[RGB_W-1:0] = shadow.mid;
      end
      REG_COARSE: begin
        shadow.coarse = value[RGB_W-1:0];
        want[RGB_W-1:0] = shadow.coarse;
      end
      REG_VAXIS: begin
        shadow.vaxis = value[RGB_W-1:0];
        want[RGB_W-1:0] = shadow.vaxis;
      end
      REG_HAXIS: begin
        shadow.haxis = value[RGB_W-1:0];
        want[RGB_W-1:0] = shadow.haxis;
      end
      default: begin
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata at %0h: expected %0h, got %0h", {idx, 2'b00}, want, prdata);
      error_count++;
    end
  endtask

  function automatic logic [APB_DW-1:0] with_color(input rgb_t c);
    logic [APB_DW-1:0] v;
    v = $urandom();
    v[RGB_W-1:0] = c;
    return v;
  endfunction

  function automatic rgb_t pick_color(input int setting);
    if (setting == 1) return 24'h000000;
    if (setting == 2) return 24'hFFFFFF;
    return rgb_t'($urandom());
  endfunction

  initial begin
    pixel_t p;
    logic [APB_DW-1:0] v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 63;
    @(posedge clk);

    foreach (probes[n]) begin
      p.pixel_row    = probes[n].row;
      p.pixel_column = probes[n].col;
      send_pixel(p, probes[n].known ? color_t'(probes[n].color) : pixel_color(p));
    end
    wait_drained();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 36;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      v = $urandom();
      v[PPU_W-1:0] = unit_settings[s];
      write_reg(REG_PPU, v);
      write_reg(REG_FINE, with_color(pick_color(s)));
      write_reg(REG_MEDIUM, with_color(pick_color(s)));
      write_reg(REG_COARSE, with_color(pick_color(s)));
      write_reg(REG_VAXIS, with_color(pick_color(s)));
      write_reg(REG_HAXIS, with_color(pick_color(s)));
      psel    <= 1'b0;
      penable <= 1'b0;
      for (int i = 0; i < PIXELS_PER_SET; i++) begin
        if (s == 4 && i == 50) holdoff_requests++;
        if (s == 5 && i == 100) wait_drained();
        p = random_pixel();
        send_pixel(p, pixel_color(p));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d pixels over %0d register settings, %0d colors checked",
             pixels_sent, NUM_SETTINGS + 1, colors_checked);
    $display("covered axis bands, grid lines, origin square, zero and extreme spacing");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gopc_pkg.sv
rtl/gopc_regs.sv
rtl/gopc_front.sv
rtl/gopc_div_step.sv
rtl/gopc_resolve.sv
rtl/grid_overlay_pixel_classifier.sv
bench/tb_top.sv
